// ----- design/assert_macros.svh -----
// Assertion macros used by the pixel linearizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TLOG_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TLOG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLOG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tlog_pkg.sv -----
// Types, constants and coefficient tables of the pixel linearizer.
package tlog_pkg;

	// Table sizes and fixed-point format.
	localparam int TRANSFER_DEPTH = 65536;
	localparam int OOTF_DEPTH     = 1024;
	localparam int FRAC_BITS      = 16;
	localparam int COEF_BITS      = 16;
	localparam int TAW            = $clog2(TRANSFER_DEPTH);
	localparam int OAW            = $clog2(OOTF_DEPTH);

	// Field widths.
	localparam int MODE_W    = 2;
	localparam int SAMPLE_W  = 16;
	localparam int INDEX_W   = 16;
	localparam int VAL_W     = 23;
	localparam int OUT_W     = 25;
	localparam int PRIM_W    = 4;
	localparam int NUM_PRIM  = 9;
	localparam int LANES     = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 4;

	// Datapath widths.
	localparam int LCOEF_W = 16;
	localparam int MCOEF_W = 18;
	localparam int LPROD_W = VAL_W + LCOEF_W;
	localparam int LSUM_W  = LPROD_W + 2;
	localparam int Y_W     = LSUM_W - COEF_BITS;
	localparam int POS_W   = Y_W + OAW;
	localparam int IDX_W   = POS_W - FRAC_BITS;
	localparam int GPROD_W = VAL_W + 1 + FRAC_BITS + 1;
	localparam int CPROD_W = 2 * VAL_W;
	localparam int CH2_W   = CPROD_W - FRAC_BITS;
	localparam int MPROD_W = MCOEF_W + CH2_W + 1;
	localparam int MSUM_W  = MPROD_W + 2;
	localparam int RND_W   = MSUM_W - COEF_BITS;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Request codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_PIXEL   = 2'd0,
		MODE_WR_XFER = 2'd1,
		MODE_WR_OOTF = 2'd2
	} mode_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARIES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OOTF_EN   = 1'd1;

	typedef logic [VAL_W-1:0]          val_t;
	typedef logic [LCOEF_W-1:0]        lcoef_t;
	typedef logic signed [MCOEF_W-1:0] mcoef_t;

	// Per-stage control that travels beside the datapath.
	typedef struct packed {
		logic               pix;
		logic               ootf_wr;
		logic               eol;
		logic [INDEX_W-1:0] idx;
		val_t               val;
	} ctl_t;

	// Interpolated gain handed from the gain unit to the lanes.
	typedef struct packed {
		val_t g;
		logic ynz;
	} gain_t;

	// Luminance weights per primaries set, Q.16.
	localparam lcoef_t LUMA_COEF [NUM_PRIM][LANES] = '{
		'{16'd13936, 16'd46869, 16'd4731},
		'{16'd17216, 16'd44433, 16'd3886},
		'{16'd13729, 16'd47290, 16'd4516},
		'{16'd15006, 16'd45334, 16'd5196},
		'{16'd19585, 16'd38457, 16'd7494},
		'{16'd14550, 16'd46311, 16'd4675},
		'{16'd13920, 16'd45944, 16'd5673},
		'{16'd16618, 16'd44456, 16'd4462},
		'{16'd15188, 16'd44057, 16'd6291}
	};

	// Conversion matrices to BT.709 primaries, row major, Q.16.
	localparam mcoef_t CONV_COEF [NUM_PRIM][LANES][LANES] = '{
		'{'{18'sd65536, 18'sd0, 18'sd0}, '{18'sd0, 18'sd65536, 18'sd0},
		  '{18'sd0, 18'sd0, 18'sd65536}},
		'{'{18'sd108822, -18'sd38512, -18'sd4774}, '{-18'sd8163, 18'sd74246, -18'sd547},
		  '{-18'sd1190, -18'sd6592, 18'sd73317}},
		'{'{18'sd75859, -18'sd10156, -18'sd167}, '{-18'sd2720, 18'sd68522, -18'sd267},
		  '{-18'sd1183, -18'sd5150, 18'sd71869}},
		'{'{18'sd80278, -18'sd14742, 18'sd0}, '{-18'sd2756, 18'sd68292, 18'sd0},
		  '{-18'sd1287, -18'sd5153, 18'sd71976}},
		'{'{18'sd97397, -18'sd26447, -18'sd5413}, '{-18'sd1645, 18'sd62523, 18'sd4658},
		  '{-18'sd1784, -18'sd2890, 18'sd70210}},
		'{'{18'sd68422, -18'sd2886, 18'sd0}, '{18'sd0, 18'sd65536, 18'sd0},
		  '{18'sd0, 18'sd773, 18'sd64763}},
		'{'{18'sd61574, 18'sd3289, 18'sd673}, '{18'sd1165, 18'sd63294, 18'sd1077},
		  '{-18'sd106, -18'sd286, 18'sd65929}},
		'{'{18'sd88223, -18'sd22229, -18'sd457}, '{-18'sd3103, 18'sd69865, -18'sd1226},
		  '{-18'sd1420, -18'sd4018, 18'sd70974}},
		'{'{18'sd67191, -18'sd1740, 18'sd85}, '{18'sd1271, 18'sd62130, 18'sd2135},
		  '{-18'sd116, -18'sd95, 18'sd65746}}
	};

	// Unknown primaries codes fall back to the identity set.
	function automatic logic [PRIM_W-1:0] prim_sel(input logic [PRIM_W-1:0] code);
		return (code < PRIM_W'(NUM_PRIM)) ? code : '0;
	endfunction

endpackage

// ----- design/tlog_if.sv -----
// Stream and configuration interfaces of the pixel linearizer.
interface tlog_px_in_if;
	logic                             valid;
	logic                             ready;
	logic [tlog_pkg::MODE_W-1:0]      mode;
	logic [tlog_pkg::SAMPLE_W-1:0]    red_sample;
	logic [tlog_pkg::SAMPLE_W-1:0]    green_sample;
	logic [tlog_pkg::SAMPLE_W-1:0]    blue_sample;
	logic                             end_of_line;
	logic [tlog_pkg::INDEX_W-1:0]     table_index;
	logic [tlog_pkg::VAL_W-1:0]       table_value;

	modport source (output valid, mode, red_sample, green_sample, blue_sample,
		end_of_line, table_index, table_value, input ready);
	modport sink (input valid, mode, red_sample, green_sample, blue_sample,
		end_of_line, table_index, table_value, output ready);
endinterface

interface tlog_px_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tlog_pkg::OUT_W-1:0]   red_linear;
	logic signed [tlog_pkg::OUT_W-1:0]   green_linear;
	logic signed [tlog_pkg::OUT_W-1:0]   blue_linear;
	logic                                line_end_out;

	modport source (output valid, red_linear, green_linear, blue_linear,
		line_end_out, input ready);
	modport sink (input valid, red_linear, green_linear, blue_linear,
		line_end_out, output ready);
endinterface

interface tlog_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tlog_pkg::CFG_IDX_W-1:0]   index;
	logic [tlog_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/transfer_lut_ootf_gamut_matrix.sv -----
// Top level of the pixel linearizer: lanes, gain unit, merging stage and handshakes.
//
// Channel   Direction  Carries
// pix_in    sink       pixels and table write requests
// pix_out   source     linear RGB results, one per pixel request
// cfg       sink       primaries_code and ootf_enable writes
//
// One request is taken every cycle while the output register is free or being taken.
// The rate is set by the single-port write, registered-read tables in each lane.
// A stalled output freezes the whole pipeline; the output register holds its result.
// Reset clears control, valid and config registers; tables are undefined until written.
`include "assert_macros.svh"

module transfer_lut_ootf_gamut_matrix (
	input logic          clk,
	input logic          arst_n,
	tlog_px_in_if.sink   pix_in,
	tlog_px_out_if.source pix_out,
	tlog_cfg_if.sink     cfg
);
	import tlog_pkg::*;

	localparam int STAGES = 11;

	logic [PRIM_W-1:0] prim_q;
	logic              ootf_en_q;
	logic [PRIM_W-1:0] sel;
	logic              en;
	logic              out_valid_q;
	logic              line_end_q;
	ctl_t              ctl_in;
	ctl_t              ctl_s [1:STAGES];
	logic              xfer_wr;
	logic [SAMPLE_W-1:0] samples [LANES];
	logic [LPROD_W-1:0]  luma_s2 [LANES];
	gain_t               gain_s7;
	mcoef_t              col_coef [LANES][LANES];
	logic signed [MPROD_W-1:0] col_s10 [LANES][LANES];
	logic signed [OUT_W-1:0]   res_s12 [LANES];

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prim_q    <= '0;
			ootf_en_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PRIMARIES: prim_q    <= cfg.data[PRIM_W-1:0];
				REG_OOTF_EN:   ootf_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign sel = prim_sel(prim_q);

	// The pipeline moves whenever the output register is free or being taken.
	assign en           = !out_valid_q || pix_out.ready;
	assign pix_in.ready = en;

	// Decode an accepted request into stage control.
	always_comb begin
		ctl_in.pix     = pix_in.valid && (pix_in.mode == MODE_PIXEL);
		ctl_in.ootf_wr = pix_in.valid && (pix_in.mode == MODE_WR_OOTF)
			&& ({1'b0, pix_in.table_index} < (INDEX_W+1)'(OOTF_DEPTH));
		ctl_in.eol     = pix_in.end_of_line;
		ctl_in.idx     = pix_in.table_index;
		ctl_in.val     = pix_in.table_value;
		xfer_wr        = pix_in.valid && en && (pix_in.mode == MODE_WR_XFER)
			&& ({1'b0, pix_in.table_index} < (INDEX_W+1)'(TRANSFER_DEPTH));
	end

	// Control pipeline beside the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= STAGES; s++) begin
				ctl_s[s] <= '0;
			end
		end else if (en) begin
			ctl_s[1] <= ctl_in;
			for (int s = 2; s <= STAGES; s++) begin
				ctl_s[s] <= ctl_s[s-1];
			end
		end
	end

	// Output handshake register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_s[STAGES].pix;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			line_end_q <= ctl_s[STAGES].eol;
		end
	end

	// Lane inputs and matrix columns for the active primaries.
	always_comb begin
		samples[0] = pix_in.red_sample;
		samples[1] = pix_in.green_sample;
		samples[2] = pix_in.blue_sample;
		for (int k = 0; k < LANES; k++) begin
			for (int r = 0; r < LANES; r++) begin
				col_coef[k][r] = CONV_COEF[sel][r][k];
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		tlog_lane u_lane (
			.clk       (clk),
			.en        (en),
			.xfer_wr   (xfer_wr),
			.xfer_addr (pix_in.table_index[TAW-1:0]),
			.xfer_data (pix_in.table_value),
			.sample    (samples[k]),
			.luma_coef (LUMA_COEF[sel][k]),
			.gain_s7   (gain_s7),
			.ootf_en   (ootf_en_q),
			.col_coef  (col_coef[k]),
			.luma_s2   (luma_s2[k]),
			.col_s10   (col_s10[k])
		);
	end

	// OOTF table writes land in the stage where pixels read the table.
	tlog_gain u_gain (
		.clk       (clk),
		.en        (en),
		.luma_s2   (luma_s2),
		.ootf_wr   (en && ctl_s[4].ootf_wr),
		.ootf_addr (ctl_s[4].idx[OAW-1:0]),
		.ootf_data (ctl_s[4].val),
		.gain_s7   (gain_s7)
	);

	tlog_mix u_mix (
		.clk     (clk),
		.en      (en),
		.col_s10 (col_s10),
		.res_s12 (res_s12)
	);

	assign pix_out.valid        = out_valid_q;
	assign pix_out.red_linear   = res_s12[0];
	assign pix_out.green_linear = res_s12[1];
	assign pix_out.blue_linear  = res_s12[2];
	assign pix_out.line_end_out = line_end_q;

	// A pixel leaving the last stage always lands in the output register.
	`TLOG_ASSERT_NEXT(a_pix_to_out, clk, arst_n, en && ctl_s[STAGES].pix, out_valid_q, "pixel result lost")
	// Stage 4 never holds a pixel and a table write at once.
	`TLOG_ASSERT(a_wr_pix_excl, clk, arst_n, !(ctl_s[4].pix && ctl_s[4].ootf_wr), "stage holds two requests")
	// A stalled pipeline keeps its last stage unchanged.
	`TLOG_ASSERT_NEXT(a_stall_hold, clk, arst_n, !en, ctl_s[STAGES] == $past(ctl_s[STAGES]), "stalled stage moved")

endmodule

// ----- design/tlog_lane.sv -----
// One color lane: transfer table, luma term, OOTF gain and matrix column products.
module tlog_lane (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic                                 xfer_wr,
	input  logic [tlog_pkg::TAW-1:0]             xfer_addr,
	input  tlog_pkg::val_t                       xfer_data,
	input  logic [tlog_pkg::SAMPLE_W-1:0]        sample,
	input  tlog_pkg::lcoef_t                     luma_coef,
	input  tlog_pkg::gain_t                      gain_s7,
	input  logic                                 ootf_en,
	input  tlog_pkg::mcoef_t                     col_coef [tlog_pkg::LANES],
	output logic [tlog_pkg::LPROD_W-1:0]         luma_s2,
	output logic signed [tlog_pkg::MPROD_W-1:0]  col_s10 [tlog_pkg::LANES]
);
	import tlog_pkg::*;

	val_t               xfer_mem [TRANSFER_DEPTH];
	logic [TAW-1:0]     rd_addr;
	val_t               ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, ch_s6, ch_s7, ch_s8;
	logic [CPROD_W-1:0] prod_s8;
	logic               ynz_s8;
	logic [CH2_W-1:0]   ch2_s9;
	logic [CH2_W-1:0]   ch2_d;

	// Samples beyond the table read its last entry.
	always_comb begin
		if ({1'b0, sample} >= (SAMPLE_W+1)'(TRANSFER_DEPTH)) begin
			rd_addr = TAW'(TRANSFER_DEPTH - 1);
		end else begin
			rd_addr = sample[TAW-1:0];
		end
	end

	// Transfer table write port.
	always_ff @(posedge clk) begin
		if (xfer_wr) begin
			xfer_mem[xfer_addr] <= xfer_data;
		end
	end

	// Transfer table read port, registered.
	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1 <= xfer_mem[rd_addr];
		end
	end

	// Luma term, then the delay line that waits for the gain.
	always_ff @(posedge clk) begin
		if (en) begin
			luma_s2 <= luma_coef * ch_s1;
			ch_s2   <= ch_s1;
			ch_s3   <= ch_s2;
			ch_s4   <= ch_s3;
			ch_s5   <= ch_s4;
			ch_s6   <= ch_s5;
			ch_s7   <= ch_s6;
			ch_s8   <= ch_s7;
			prod_s8 <= ch_s7 * gain_s7.g;
			ynz_s8  <= gain_s7.ynz;
		end
	end

	// Apply the gain with rounding when OOTF is enabled, else pass the channel; zero luminance gives black.
	always_comb begin
		if (!ootf_en) begin
			ch2_d = CH2_W'(ch_s8);
		end else if (!ynz_s8) begin
			ch2_d = '0;
		end else begin
			ch2_d = CH2_W'((prod_s8 + CPROD_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		end
	end

	// Column products of the conversion matrix.
	always_ff @(posedge clk) begin
		if (en) begin
			ch2_s9 <= ch2_d;
			for (int r = 0; r < LANES; r++) begin
				col_s10[r] <= col_coef[r] * $signed({1'b0, ch2_s9});
			end
		end
	end

endmodule

// ----- design/tlog_gain.sv -----
// Luminance sum, OOTF table lookup and linear interpolation of the gain.
module tlog_gain (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tlog_pkg::LPROD_W-1:0]  luma_s2 [tlog_pkg::LANES],
	input  logic                          ootf_wr,
	input  logic [tlog_pkg::OAW-1:0]      ootf_addr,
	input  tlog_pkg::val_t                ootf_data,
	output tlog_pkg::gain_t               gain_s7
);
	import tlog_pkg::*;

	val_t                       ootf_mem [OOTF_DEPTH];
	logic [LSUM_W-1:0]          lsum;
	logic [Y_W-1:0]             y_s3;
	logic [POS_W-1:0]           pos_s4;
	logic                       ynz_s4, ynz_s5, ynz_s6;
	logic [IDX_W-1:0]           idx;
	logic                       clamp;
	logic [OAW-1:0]             a_addr, b_addr;
	val_t                       a_s5, b_s5, a_s6;
	logic [FRAC_BITS-1:0]       frac_s5;
	logic signed [VAL_W:0]      diff;
	logic signed [GPROD_W-1:0]  prod_s6;
	logic signed [GPROD_W-1:0]  rnd;
	logic signed [GPROD_W-1:0]  gsum;

	// Luminance, rounded from Q.16 coefficients.
	always_comb begin
		lsum = LSUM_W'(luma_s2[0]) + LSUM_W'(luma_s2[1]) + LSUM_W'(luma_s2[2])
			+ LSUM_W'(1 << (COEF_BITS - 1));
	end

	// Table position split into index and fraction; the top entry saturates.
	always_comb begin
		idx   = pos_s4[POS_W-1:FRAC_BITS];
		clamp = idx >= IDX_W'(OOTF_DEPTH - 1);
		if (clamp) begin
			a_addr = OAW'(OOTF_DEPTH - 1);
			b_addr = OAW'(OOTF_DEPTH - 1);
		end else begin
			a_addr = idx[OAW-1:0];
			b_addr = idx[OAW-1:0] + OAW'(1);
		end
	end

	// OOTF table write port.
	always_ff @(posedge clk) begin
		if (ootf_wr) begin
			ootf_mem[ootf_addr] <= ootf_data;
		end
	end

	// Luminance, position and the two registered table reads.
	always_ff @(posedge clk) begin
		if (en) begin
			y_s3    <= Y_W'(lsum >> COEF_BITS);
			pos_s4  <= POS_W'(y_s3) * POS_W'(OOTF_DEPTH - 1);
			ynz_s4  <= y_s3 != '0;
			a_s5    <= ootf_mem[a_addr];
			b_s5    <= ootf_mem[b_addr];
			frac_s5 <= clamp ? '0 : pos_s4[FRAC_BITS-1:0];
			ynz_s5  <= ynz_s4;
		end
	end

	// Slope times fraction.
	always_comb begin
		diff = $signed({1'b0, b_s5}) - $signed({1'b0, a_s5});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6 <= diff * $signed({1'b0, frac_s5});
			a_s6    <= a_s5;
			ynz_s6  <= ynz_s5;
		end
	end

	// Round half away from zero and add the base entry.
	always_comb begin
		if (prod_s6 >= 0) begin
			rnd = (prod_s6 + GPROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		end else begin
			rnd = -((-prod_s6 + GPROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
		end
		gsum = rnd + $signed(GPROD_W'(a_s6));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gain_s7.g   <= gsum[VAL_W-1:0];
			gain_s7.ynz <= ynz_s6;
		end
	end

endmodule

// ----- design/tlog_mix.sv -----
// Merging stage: matrix row sums, rounding and output saturation.
module tlog_mix (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [tlog_pkg::MPROD_W-1:0]  col_s10 [tlog_pkg::LANES][tlog_pkg::LANES],
	output logic signed [tlog_pkg::OUT_W-1:0]    res_s12 [tlog_pkg::LANES]
);
	import tlog_pkg::*;

	logic signed [MSUM_W-1:0] sum_s11 [LANES];
	logic signed [MSUM_W-1:0] rnd [LANES];

	// Row sums over the lanes' column products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < LANES; r++) begin
				sum_s11[r] <= MSUM_W'(col_s10[0][r]) + MSUM_W'(col_s10[1][r])
					+ MSUM_W'(col_s10[2][r]);
			end
		end
	end

	// Round half away from zero.
	always_comb begin
		for (int r = 0; r < LANES; r++) begin
			if (sum_s11[r] >= 0) begin
				rnd[r] = (sum_s11[r] + MSUM_W'(1 << (COEF_BITS - 1))) >>> COEF_BITS;
			end else begin
				rnd[r] = -((-sum_s11[r] + MSUM_W'(1 << (COEF_BITS - 1))) >>> COEF_BITS);
			end
		end
	end

	// Saturate into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < LANES; r++) begin
				if (rnd[r] > MSUM_W'(OUT_MAX)) begin
					res_s12[r] <= OUT_MAX;
				end else if (rnd[r] < MSUM_W'(OUT_MIN)) begin
					res_s12[r] <= OUT_MIN;
				end else begin
					res_s12[r] <= rnd[r][OUT_W-1:0];
				end
			end
		end
	end

endmodule

// ----- test/tb_transfer_lut_ootf_gamut_matrix.sv -----
// Self-checking testbench for the pixel linearizer: table loads, pixels, and several primaries sets and unknown codes.
`timescale 1ns / 1ps

module tb_transfer_lut_ootf_gamut_matrix;
	import tlog_pkg::*;

	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 24;
	localparam val_t VAL_MAX = {VAL_W{1'b1}};

	// One request on the pixel stream.
	typedef struct {
		logic [MODE_W-1:0]   mode;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
		logic                eol;
		logic [INDEX_W-1:0]  idx;
		val_t                val;
		bit                  typed;
		logic signed [OUT_W-1:0] exp_val;
	} px_req_t;

	// One linear pixel result.
	typedef struct {
		logic signed [OUT_W-1:0] red;
		logic signed [OUT_W-1:0] green;
		logic signed [OUT_W-1:0] blue;
		logic                    eol;
	} px_res_t;

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   error_count;

	tlog_px_in_if  pix_in_bus ();
	tlog_px_out_if pix_out_bus ();
	tlog_cfg_if    cfg_bus ();

	transfer_lut_ootf_gamut_matrix u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.cfg     (cfg_bus)
	);

	// Shadow state of the linearizer.
	val_t            xfer_lut [TRANSFER_DEPTH];
	val_t            gain_lut [OOTF_DEPTH];
	bit              xfer_seen [TRANSFER_DEPTH];
	bit              gain_seen [OOTF_DEPTH];
	int              xfer_written [$];
	logic [PRIM_W-1:0] prim_code;
	logic            ootf_on;
	px_res_t         linear_pending [$];

	// Clock and watchdog.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint round_q(input longint v, input int n);
		longint half;
		half = longint'(1) << (n - 1);
		if (v >= 0)
			return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	function automatic longint clamp_out(input longint v);
		if (v > 16777215)
			return 16777215;
		if (v < -16777216)
			return -16777216;
		return v;
	endfunction

	// Interpolated OOTF gain for a positive luminance.
	function automatic longint interp_gain(input longint y);
		longint pos, gi, frac, a, b;
		pos = y * (OOTF_DEPTH - 1);
		gi = pos >>> FRAC_BITS;
		frac = pos & ((longint'(1) << FRAC_BITS) - 1);
		if (gi >= OOTF_DEPTH - 1)
			return longint'(gain_lut[OOTF_DEPTH-1]);
		a = longint'(gain_lut[gi]);
		b = longint'(gain_lut[gi+1]);
		return a + round_q((b - a) * frac, FRAC_BITS);
	endfunction

	// Full pixel path: table lookup, optional gain, primaries conversion.
	function automatic px_res_t linearize(input px_req_t r);
		px_res_t res;
		longint ch [3];
		longint out [3];
		longint y, g, acc;
		int sel;
		sel = (prim_code < NUM_PRIM) ? int'(prim_code) : 0;
		ch[0] = longint'(xfer_lut[r.red]);
		ch[1] = longint'(xfer_lut[r.green]);
		ch[2] = longint'(xfer_lut[r.blue]);
		if (ootf_on) begin
			y = 0;
			for (int k = 0; k < 3; k++)
				y += longint'(LUMA_COEF[sel][k]) * ch[k];
			y = round_q(y, COEF_BITS);
			if (y <= 0) begin
				for (int k = 0; k < 3; k++)
					ch[k] = 0;
			end else begin
				g = interp_gain(y);
				for (int k = 0; k < 3; k++)
					ch[k] = round_q(ch[k] * g, FRAC_BITS);
			end
		end
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += longint'(CONV_COEF[sel][k][j]) * ch[j];
			out[k] = clamp_out(round_q(acc, COEF_BITS));
		end
		res.red = out[0][OUT_W-1:0];
		res.green = out[1][OUT_W-1:0];
		res.blue = out[2][OUT_W-1:0];
		res.eol = r.eol;
		return res;
	endfunction

	// Apply an accepted request to the shadow state and queue its result.
	task automatic apply_request(input px_req_t r);
		px_res_t res;
		case (r.mode)
			MODE_WR_XFER: begin
				xfer_lut[r.idx] = r.val;
				if (!xfer_seen[r.idx]) begin
					xfer_seen[r.idx] = 1'b1;
					xfer_written.push_back(int'(r.idx));
				end
			end
			MODE_WR_OOTF: begin
				if (r.idx < OOTF_DEPTH) begin
					gain_lut[r.idx] = r.val;
					gain_seen[r.idx] = 1'b1;
				end
			end
			MODE_PIXEL: begin
				if (r.typed) begin
					res.red = r.exp_val;
					res.green = r.exp_val;
					res.blue = r.exp_val;
					res.eol = r.eol;
				end else begin
					res = linearize(r);
				end
				linear_pending.push_back(res);
			end
			default: ;
		endcase
	endtask

	// Send one request after a gap; valid stays high when the next gap is zero.
	task automatic send_request(input px_req_t r, input int gap);
		if (gap > 0) begin
			pix_in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_bus.valid <= 1'b1;
		pix_in_bus.mode <= r.mode;
		pix_in_bus.red_sample <= r.red;
		pix_in_bus.green_sample <= r.green;
		pix_in_bus.blue_sample <= r.blue;
		pix_in_bus.end_of_line <= r.eol;
		pix_in_bus.table_index <= r.idx;
		pix_in_bus.table_value <= r.val;
		do
			@(posedge clk);
		while (!pix_in_bus.ready);
		apply_request(r);
	endtask

	task automatic stream_idle();
		pix_in_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write one register once the pipeline has drained.
	task automatic write_register(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DAT_W-1:0] d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= ri;
		cfg_bus.data <= d;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (ri == REG_PRIMARIES)
			prim_code = d;
		else
			ootf_on = d[0];
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (linear_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// Result sink with random stalls.
	initial begin
		int stall;
		px_res_t want;
		pix_out_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				pix_out_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_out_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(pix_out_bus.valid && pix_out_bus.ready));
			if (linear_pending.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = linear_pending.pop_front();
				if (pix_out_bus.red_linear !== want.red)
					report_mismatch("red_linear", pix_out_bus.red_linear, want.red);
				if (pix_out_bus.green_linear !== want.green)
					report_mismatch("green_linear", pix_out_bus.green_linear, want.green);
				if (pix_out_bus.blue_linear !== want.blue)
					report_mismatch("blue_linear", pix_out_bus.blue_linear, want.blue);
				if (pix_out_bus.line_end_out !== want.eol)
					report_mismatch("line_end_out", pix_out_bus.line_end_out, want.eol);
			end
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		if ($urandom_range(0, 9) == 0)
			return '0;
		return SAMPLE_W'(xfer_written[$urandom_range(0, xfer_written.size() - 1)]);
	endfunction

	function automatic val_t pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return VAL_MAX;
			2: return val_t'($urandom_range(0, 131072));
			default: return val_t'($urandom);
		endcase
	endfunction

	function automatic px_req_t make_req(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] r,
		input logic [SAMPLE_W-1:0] g, input logic [SAMPLE_W-1:0] b, input logic eol,
		input logic [INDEX_W-1:0] ti, input val_t tv);
		px_req_t q;
		q.mode = m;
		q.red = r;
		q.green = g;
		q.blue = b;
		q.eol = eol;
		q.idx = ti;
		q.val = tv;
		q.typed = 1'b0;
		q.exp_val = '0;
		return q;
	endfunction

	// Random request mix: mostly pixels over loaded entries, some loads and noise.
	function automatic px_req_t random_req();
		int pick;
		px_req_t q;
		pick = $urandom_range(0, 99);
		q = make_req(MODE_PIXEL, pick_sample(), pick_sample(), pick_sample(),
			1'($urandom_range(0, 1)), INDEX_W'($urandom), val_t'($urandom));
		if (pick < 10) begin
			q.mode = MODE_WR_XFER;
			q.val = pick_value();
		end else if (pick < 14) begin
			q.mode = MODE_WR_OOTF;
			q.idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(0, 1023));
			q.val = pick_value();
		end else if (pick < 17) begin
			q.mode = MODE_IGNORED;
		end
		return q;
	endfunction

	// Load the OOTF entries that a pixel interpolates between, where still unloaded.
	task automatic load_gain_for(input px_req_t r);
		longint y, gi, lo, hi;
		int sel;
		sel = (prim_code < NUM_PRIM) ? int'(prim_code) : 0;
		if (!ootf_on || r.mode != MODE_PIXEL)
			return;
		y = longint'(LUMA_COEF[sel][0]) * longint'(xfer_lut[r.red])
			+ longint'(LUMA_COEF[sel][1]) * longint'(xfer_lut[r.green])
			+ longint'(LUMA_COEF[sel][2]) * longint'(xfer_lut[r.blue]);
		y = round_q(y, COEF_BITS);
		if (y <= 0)
			return;
		gi = (y * (OOTF_DEPTH - 1)) >>> FRAC_BITS;
		if (gi >= OOTF_DEPTH - 1) begin
			lo = OOTF_DEPTH - 1;
			hi = lo;
		end else begin
			lo = gi;
			hi = gi + 1;
		end
		for (longint e = lo; e <= hi; e++) begin
			if (!gain_seen[e])
				send_request(make_req(MODE_WR_OOTF, '0, '0, '0, 1'b0, INDEX_W'(e), pick_value()),
					$urandom_range(0, 10));
		end
	endtask

	// Main sequence.
	initial begin
		px_req_t dir_rows [$];
		px_req_t q;
		logic [PRIM_W-1:0] phase_prim [8];
		logic phase_ootf [8];
		int fill;

		phase_prim = '{4'd0, 4'd0, 4'd1, 4'd8, 4'd15, 4'd4, 4'd9, 4'd7};
		phase_ootf = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		cycle_count = 0;
		error_count = 0;
		prim_code = '0;
		ootf_on = 1'b0;
		arst_n = 1'b0;
		pix_in_bus.valid <= 1'b0;
		pix_in_bus.mode <= MODE_PIXEL;
		pix_in_bus.red_sample <= '0;
		pix_in_bus.green_sample <= '0;
		pix_in_bus.blue_sample <= '0;
		pix_in_bus.end_of_line <= 1'b0;
		pix_in_bus.table_index <= '0;
		pix_in_bus.table_value <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_PRIMARIES;
		cfg_bus.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, every request kind, ignored writes.
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'd0, '0));
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'hFFFF, VAL_MAX));
		q = make_req(MODE_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0, '0);
		q.typed = 1'b1;
		q.exp_val = 25'sd8388607;
		dir_rows.push_back(q);
		q = make_req(MODE_PIXEL, '0, '0, '0, 1'b0, 16'hFFFF, VAL_MAX);
		q.typed = 1'b1;
		q.exp_val = '0;
		dir_rows.push_back(q);
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'd1, 23'd65536));
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'h8000, 23'h400000));
		dir_rows.push_back(make_req(MODE_PIXEL, 16'd1, 16'h8000, 16'hFFFF, 1'b1, '0, '0));
		dir_rows.push_back(make_req(MODE_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF,
			VAL_MAX));
		dir_rows.push_back(make_req(MODE_WR_OOTF, '0, '0, '0, 1'b0, 16'hFFFF, VAL_MAX));
		dir_rows.push_back(make_req(MODE_WR_OOTF, '0, '0, '0, 1'b0, 16'd1024, VAL_MAX));
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'hAAAA, 23'h2AAAAA));
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'h5555, 23'h555555));
		dir_rows.push_back(make_req(MODE_PIXEL, 16'hAAAA, 16'h5555, 16'd0, 1'b1, '0, '0));
		dir_rows.push_back(make_req(MODE_PIXEL, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, '0, '0));
		dir_rows.push_back(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, 16'hAAAA, 23'd1));
		dir_rows.push_back(make_req(MODE_PIXEL, 16'hAAAA, 16'hAAAA, 16'hAAAA, 1'b1, '0, '0));
		foreach (dir_rows[i])
			send_request(dir_rows[i], $urandom_range(0, 10));

		// Load a spread of transfer entries; gain entries are loaded as pixels need them.
		for (int i = 0; i < 120; i++)
			send_request(make_req(MODE_WR_XFER, '0, '0, '0, 1'b0, INDEX_W'($urandom), pick_value()),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0);

		// Random phases, each under its own register setting.
		for (int p = 0; p < 8; p++) begin
			stream_idle();
			wait_drained();
			write_register(REG_PRIMARIES, phase_prim[p]);
			write_register(REG_OOTF_EN, {3'b000, phase_ootf[p]});
			fill = 0;
			while (fill < 65) begin
				q = random_req();
				if (q.mode != MODE_IGNORED)
					fill++;
				load_gain_for(q);
				send_request(q, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10));
			end
		end

		stream_idle();
		wait_drained();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- transfer_lut_ootf_gamut_matrix.f -----
+incdir+design
design/tlog_pkg.sv
design/tlog_if.sv
design/tlog_lane.sv
design/tlog_gain.sv
design/tlog_mix.sv
design/transfer_lut_ootf_gamut_matrix.sv
test/tb_transfer_lut_ootf_gamut_matrix.sv
